// File: hdl/lru_batch_evict_pair_cache_assert.svh
// Assertion macros for the LRU batch-evict pair cache.
// Included by the top level; needs nothing else.
`ifndef LRU_BATCH_EVICT_PAIR_CACHE_ASSERT_SVH
`define LRU_BATCH_EVICT_PAIR_CACHE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define LBE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbe: same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define LBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbe: next-cycle check failed");

`endif

// File: hdl/lbe_pkg.sv
// Shared types and constants for the LRU batch-evict pair cache.
// No dependencies; the interfaces, the top level, lbe_ctrl and lbe_datapath import it.
package lbe_pkg;

   localparam int unsigned CAPACITY_DEF    = 64;
   localparam int unsigned PRUNE_COUNT_DEF = 8;
   localparam int unsigned KEY_W           = 32;
   localparam int unsigned ID_W            = 32;
   localparam int unsigned STAMP_W         = 32;
   localparam int unsigned EVICT_W         = 7;

   // One stored slot, kept as one memory row
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   bkey;
      logic [KEY_W-1:0]   skey;
      logic [ID_W-1:0]    entry_id;
      logic [STAMP_W-1:0] stamp;
   } row_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT_SCAN,
      ST_EVICT_WRITE,
      ST_UPDATE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_start;
      logic scan;
      logic evict_mode;
      logic evict_commit;
      logic clear;
      logic update;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic scan_done;
      logic found;
      logic full;
      logic evict_last;
      logic out_free;
   } sts_type;

endpackage

// File: hdl/lbe_req_if.sv
// Request channel of the pair cache: valid/ready plus the key pair.
// Depends on lbe_pkg for field widths.
interface lbe_req_if;
   import lbe_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] buffer_decl_id;
   logic [KEY_W-1:0] shader_decl_id;

   modport source (output valid, output buffer_decl_id, output shader_decl_id, input ready);
   modport sink (input valid, input buffer_decl_id, input shader_decl_id, output ready);

endinterface

// File: hdl/lbe_rsp_if.sv
// Response channel of the pair cache: valid/ready plus hit, id and evict count.
// Depends on lbe_pkg for field widths.
interface lbe_rsp_if;
   import lbe_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic [ID_W-1:0]    entry_id;
   logic [EVICT_W-1:0] evicted_count;

   modport source (output valid, output hit, output entry_id, output evicted_count,
                   input ready);
   modport sink (input valid, input hit, input entry_id, input evicted_count,
                 output ready);

endinterface

// File: hdl/lru_batch_evict_pair_cache.sv
// Fully associative pair cache with LRU batch eviction.
//
// Use: send a key pair (buffer_decl_id, shader_decl_id) on req_bus; one
// response per request comes back on rsp_bus with hit, entry_id and
// evicted_count. Both channels use valid/ready; a request or response
// moves on a clock edge where both are high.
// Flow: a request walks the slot memory one slot per cycle. A hit
// ends the lookup at the matching slot, a miss on a table with room
// scans every slot, and a miss on a full table adds min(PRUNE_COUNT,
// CAPACITY) eviction passes over every slot. The single read port of
// the slot memory sets this pace. One request is in work at a time;
// the next request can be taken in the cycle after the response is
// loaded.
// Reset: synchronous, active high. Afterwards a clearing pass
// invalidates every slot in turn; req_bus.ready stays low during it.
// Stall: the response waits in an output register; the next request is
// still accepted, and its own response waits until the register frees.
// Depends on lbe_pkg, the channel interfaces, the assertion header, lbe_ctrl, lbe_datapath.
module lru_batch_evict_pair_cache #(
   parameter int unsigned CAPACITY    = lbe_pkg::CAPACITY_DEF,
   parameter int unsigned PRUNE_COUNT = lbe_pkg::PRUNE_COUNT_DEF
) (
   input logic      clock,
   input logic      reset,
   lbe_req_if.sink  req_bus,
   lbe_rsp_if.source rsp_bus
);
   import lbe_pkg::*;

   `include "lru_batch_evict_pair_cache_assert.svh"

   localparam int unsigned NEvict = (PRUNE_COUNT < CAPACITY) ? PRUNE_COUNT : CAPACITY;

   cmd_type cmd;
   sts_type sts;
   logic    req_fire;
   logic    evict_ok;

   lbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lbe_datapath #(
      .CAPACITY    (CAPACITY),
      .PRUNE_COUNT (PRUNE_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_bkey          (req_bus.buffer_decl_id),
      .req_skey          (req_bus.shader_decl_id),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_hit           (rsp_bus.hit),
      .rsp_entry_id      (rsp_bus.entry_id),
      .rsp_evicted_count (rsp_bus.evicted_count)
   );

   // Terms for the checks below
   assign req_fire = req_bus.valid && req_bus.ready;
   assign evict_ok = (rsp_bus.evicted_count == '0)
                     || (!rsp_bus.hit && (rsp_bus.evicted_count == EVICT_W'(NEvict)));

   // One request in work at a time
   `LBE_ASSERT_NEXT(a_busy_after_request, clock, reset, req_fire, !req_bus.ready)

   // Clearing pass blocks requests right after reset
   `LBE_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_bus.ready)

   // Hits evict nothing; misses evict nothing or a full batch
   `LBE_ASSERT_SAME(a_evict_count, clock, reset, rsp_bus.valid, evict_ok)

endmodule

// File: hdl/lbe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lbe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one row; read one row, with the read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lbe_ctrl.sv
// Controller state machine of the pair cache: sequences clear, lookup,
// eviction passes and the final update. Depends on lbe_pkg.
module lbe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lbe_pkg::sts_type sts,
   output lbe_pkg::cmd_type cmd
);
   import lbe_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the next state and drive commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.scan = 1'b1;
            if (sts.found) begin
               state_in = ST_UPDATE;
            end else if (sts.scan_done) begin
               if (sts.full) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_EVICT_SCAN;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_EVICT_SCAN: begin
            cmd.scan       = 1'b1;
            cmd.evict_mode = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_EVICT_WRITE;
            end
         end
         ST_EVICT_WRITE: begin
            cmd.evict_commit = 1'b1;
            if (sts.evict_last) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_EVICT_SCAN;
            end
         end
         ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hdl/lbe_datapath.sv
// Datapath of the pair cache: slot memory, scan counter, match and
// oldest-stamp trackers, use/id counters and the response register.
// Depends on lbe_pkg and lbe_ram.
module lbe_datapath #(
   parameter int unsigned CAPACITY    = lbe_pkg::CAPACITY_DEF,
   parameter int unsigned PRUNE_COUNT = lbe_pkg::PRUNE_COUNT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lbe_pkg::cmd_type          cmd,
   output lbe_pkg::sts_type          sts,
   input  logic [lbe_pkg::KEY_W-1:0] req_bkey,
   input  logic [lbe_pkg::KEY_W-1:0] req_skey,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic [lbe_pkg::ID_W-1:0]  rsp_entry_id,
   output logic [lbe_pkg::EVICT_W-1:0] rsp_evicted_count
);
   import lbe_pkg::*;

   localparam int unsigned IdxW   = $clog2(CAPACITY);
   localparam int unsigned CntW   = $clog2(CAPACITY + 1);
   localparam int unsigned NEvict = (PRUNE_COUNT < CAPACITY) ? PRUNE_COUNT : CAPACITY;
   localparam int unsigned RowW   = $bits(row_type);

   // Registers
   logic [KEY_W-1:0]   bkey_ff, bkey_in;
   logic [KEY_W-1:0]   skey_ff, skey_in;
   logic [CntW-1:0]    issue_ff, issue_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IdxW-1:0]    chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [IdxW-1:0]    slot_ff, slot_in;
   logic [ID_W-1:0]    hit_id_ff, hit_id_in;
   logic               free_found_ff, free_found_in;
   logic [IdxW-1:0]    free_ff, free_in;
   logic               best_found_ff, best_found_in;
   logic [IdxW-1:0]    best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [EVICT_W-1:0] evict_cnt_ff, evict_cnt_in;
   logic [STAMP_W-1:0] use_ff, use_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [CntW-1:0]    occ_ff, occ_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [EVICT_W-1:0] rsp_evict_ff, rsp_evict_in;

   // Memory port signals
   logic            issuing;
   logic            chk;
   logic            rd_en;
   logic [IdxW-1:0] rd_addr;
   logic [RowW-1:0] rd_data;
   row_type         row;
   logic            key_match;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   row_type         wr_row;

   lbe_ram #(
      .WIDTH (RowW),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Issue one slot read a cycle while scanning
   assign issuing   = cmd.scan && (issue_ff != CntW'(CAPACITY));
   assign rd_en     = issuing;
   assign rd_addr   = issue_ff[IdxW-1:0];
   assign row       = row_type'(rd_data);
   assign chk       = chk_valid_ff && cmd.scan;
   assign key_match = row.valid && (row.bkey == bkey_ff) && (row.skey == skey_ff);

   // Status to the controller
   always_comb begin
      sts            = '0;
      sts.clear_last = (issue_ff == CntW'(CAPACITY - 1));
      sts.scan_done  = (issue_ff == CntW'(CAPACITY)) && !chk_valid_ff;
      sts.found      = found_ff;
      sts.full       = (occ_ff >= CntW'(CAPACITY));
      sts.evict_last = (evict_cnt_ff == EVICT_W'(NEvict - 1));
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Select the memory write: clear, evict or final update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_row  = '0;
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = issue_ff[IdxW-1:0];
      end else if (cmd.evict_commit && best_found_ff) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
      end else if (cmd.update) begin
         wr_en        = 1'b1;
         wr_row.valid = 1'b1;
         wr_row.bkey  = bkey_ff;
         wr_row.skey  = skey_ff;
         if (found_ff) begin
            wr_addr         = slot_ff;
            wr_row.entry_id = hit_id_ff;
            wr_row.stamp    = use_ff + STAMP_W'(1);
         end else begin
            wr_addr         = free_ff;
            wr_row.entry_id = next_id_ff;
            wr_row.stamp    = use_ff + STAMP_W'(2);
         end
      end
   end

   // Next values of the datapath registers
   always_comb begin
      bkey_in       = bkey_ff;
      skey_in       = skey_ff;
      issue_in      = issue_ff;
      chk_valid_in  = issuing;
      chk_idx_in    = issue_ff[IdxW-1:0];
      found_in      = found_ff;
      slot_in       = slot_ff;
      hit_id_in     = hit_id_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      evict_cnt_in  = evict_cnt_ff;
      use_in        = use_ff;
      next_id_in    = next_id_ff;
      occ_in        = occ_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_evict_in  = rsp_evict_ff;

      // Advance the scan / clear pointer
      if (cmd.clear) begin
         issue_in = issue_ff + CntW'(1);
      end else if (cmd.accept || cmd.scan_start) begin
         issue_in = '0;
      end else if (issuing) begin
         issue_in = issue_ff + CntW'(1);
      end

      // Latch the request and reset the trackers
      if (cmd.accept) begin
         bkey_in       = req_bkey;
         skey_in       = req_skey;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         evict_cnt_in  = '0;
      end
      if (cmd.scan_start) begin
         best_found_in = 1'b0;
      end

      // Lookup: first matching slot, lowest free slot
      if (chk && !cmd.evict_mode) begin
         if (key_match && !found_ff) begin
            found_in  = 1'b1;
            slot_in   = chk_idx_ff;
            hit_id_in = row.entry_id;
         end
         if (!row.valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_in       = chk_idx_ff;
         end
      end

      // Eviction pass: oldest valid stamp, lowest index on ties
      if (chk && cmd.evict_mode) begin
         if (row.valid && (!best_found_ff || (row.stamp < best_stamp_ff))) begin
            best_found_in = 1'b1;
            best_idx_in   = chk_idx_ff;
            best_stamp_in = row.stamp;
         end
      end

      // Drop the chosen slot and keep the lowest freed index
      if (cmd.evict_commit) begin
         evict_cnt_in = evict_cnt_ff + EVICT_W'(1);
         if (best_found_ff) begin
            occ_in = occ_ff - CntW'(1);
            if (!free_found_ff || (best_idx_ff < free_ff)) begin
               free_found_in = 1'b1;
               free_in       = best_idx_ff;
            end
         end
      end

      // Final access: bump counters and load the response
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = found_ff;
         if (found_ff) begin
            use_in       = use_ff + STAMP_W'(1);
            rsp_id_in    = hit_id_ff;
            rsp_evict_in = '0;
         end else begin
            use_in       = use_ff + STAMP_W'(2);
            next_id_in   = next_id_ff + ID_W'(1);
            occ_in       = occ_ff + CntW'(1);
            rsp_id_in    = next_id_ff;
            rsp_evict_in = evict_cnt_ff;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= '0;
         chk_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         evict_cnt_ff  <= '0;
         use_ff        <= '0;
         next_id_ff    <= ID_W'(1);
         occ_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         issue_ff      <= issue_in;
         chk_valid_ff  <= chk_valid_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         best_found_ff <= best_found_in;
         evict_cnt_ff  <= evict_cnt_in;
         use_ff        <= use_in;
         next_id_ff    <= next_id_in;
         occ_ff        <= occ_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bkey_ff       <= bkey_in;
      skey_ff       <= skey_in;
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      hit_id_ff     <= hit_id_in;
      free_ff       <= free_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_evict_ff  <= rsp_evict_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_entry_id      = rsp_id_ff;
   assign rsp_evicted_count = rsp_evict_ff;

endmodule
